// ===== design/frame_difference_motion_detector_assert.svh =====
// Assertion macros for the frame difference motion detector RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdmd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdmd assertion failed");

`endif

// ===== design/fdmd_pkg.sv =====
// Package for the frame difference motion detector: sizes, constants,
// register indexes and the structs passed between the front, queue and back.
package fdmd_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int POS_W      = $clog2(MAX_PIXELS + 1);
  localparam int LUMA_W     = 8;
  localparam int CNT_W      = 17;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [LUMA_W-1:0] PIX_MAX   = 8'd255;
  localparam int                DIM_SHIFT = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_SQUELCH   = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_PLAIN     = 2'd2;

  localparam logic [LUMA_W-1:0] SQUELCH_RST   = 8'd50;
  localparam logic [CNT_W-1:0]  THRESHOLD_RST = 17'd100;

  typedef struct packed {
    logic [LUMA_W-1:0] squelch;
    logic [CNT_W-1:0]  threshold;
    logic              plain;
  } fdmd_cfg_t;

  typedef struct packed {
    logic [LUMA_W-1:0] luma;
    logic [LUMA_W-1:0] old_luma;
    logic              masked;
    logic              last;
    logic              compare_valid;
    logic              in_range;
  } fdmd_item_t;

endpackage

// ===== design/fdmd_front.sv =====
// Front part: accepts pixel items, tracks frame position and reference state,
// and reads and rewrites the frame store. Depends on fdmd_pkg.
module fdmd_front import fdmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // luma
  input  logic [1:0]        in_tuser,   // masked, restart_reference
  input  logic              in_tlast,   // last_pixel
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output fdmd_item_t        push_item
);

  logic [LUMA_W-1:0] store [MAX_PIXELS];

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              have_ref_r, have_ref_nxt;
  logic              s1_valid_r;
  logic [LUMA_W-1:0] rd_data_r;
  fdmd_item_t        s1_item_r;

  logic              accept;
  logic              first_pix;
  logic              in_range;
  logic              valid_now;
  logic [ADDR_W-1:0] addr;

  assign in_tready = (q_count + QCNT_W'(s1_valid_r)) < QCNT_W'(QDEPTH);
  assign accept    = in_tvalid & in_tready;
  assign first_pix = (pos_r == '0);
  assign in_range  = (pos_r < POS_W'(MAX_PIXELS));
  assign valid_now = have_ref_r & ~(first_pix & in_tuser[1]);
  assign addr      = pos_r[ADDR_W-1:0];

  always_comb begin
    pos_nxt      = pos_r;
    have_ref_nxt = have_ref_r;
    if (accept) begin
      have_ref_nxt = valid_now;
      if (in_range) begin
        pos_nxt = pos_r + 1'b1;
      end
      if (in_tlast) begin
        pos_nxt      = '0;
        have_ref_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= store[addr];
      if (in_range) begin
        store[addr] <= in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      have_ref_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      have_ref_r <= have_ref_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.luma          <= in_tdata;
      s1_item_r.old_luma      <= '0;
      s1_item_r.masked        <= in_tuser[0];
      s1_item_r.last          <= in_tlast;
      s1_item_r.compare_valid <= valid_now;
      s1_item_r.in_range      <= in_range;
    end
  end

  always_comb begin
    push_item          = s1_item_r;
    push_item.old_luma = s1_item_r.in_range ? rd_data_r : s1_item_r.luma;
  end

  assign push = s1_valid_r;

endmodule

// ===== design/fdmd_queue.sv =====
// Short item queue between the front and back parts.
// Depends on fdmd_pkg and the assertion macro header.
`include "frame_difference_motion_detector_assert.svh"

module fdmd_queue import fdmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fdmd_item_t        push_item,
  input  logic              pop,
  output logic              head_valid,
  output fdmd_item_t        head_item,
  output logic [QCNT_W-1:0] count
);

  fdmd_item_t        entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign count      = count_r;

  `FDMD_ASSERT_NOW(a_no_overrun, push, (count_r < QCNT_W'(QDEPTH)) || pop)
  `FDMD_ASSERT_NOW(a_no_underrun, pop, count_r != '0)
  `FDMD_ASSERT_NEXT(a_ptr_gap, 1'b1,
                    QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r))

endmodule

// ===== design/fdmd_back.sv =====
// Back part: computes the luma change, frame counts and overlay pixel for
// each queued item and holds the result item in an output register. Depends on fdmd_pkg.
module fdmd_back import fdmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fdmd_cfg_t   cfg,
  input  logic        head_valid,
  input  fdmd_item_t  head_item,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic [CNT_W-1:0]  changed_r, changed_nxt, quiet_r, quiet_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r;
  logic [LUMA_W-1:0] red_r, green_r, blue_r;
  logic [CNT_W-1:0]  ch_out_r, qt_out_r;
  logic              cmp_r, motion_r, ovf_out_r, last_r;

  logic [LUMA_W-1:0] diff, dim, red, green, blue;
  logic              changed, counted;
  logic [CNT_W-1:0]  ch_new, qt_new;
  logic              ovf_new;

  assign pop = head_valid & (~out_valid_r | out_tready);

  assign diff = (head_item.old_luma > head_item.luma) ?
                (head_item.old_luma - head_item.luma) :
                (head_item.luma - head_item.old_luma);
  assign changed = head_item.in_range & (diff > cfg.squelch);
  assign dim     = head_item.luma >> DIM_SHIFT;
  assign counted = head_item.compare_valid & head_item.in_range & ~head_item.masked;

  always_comb begin
    ch_new = changed_r;
    qt_new = quiet_r;
    if (counted && changed && changed_r != COUNT_MAX) begin
      ch_new = changed_r + 1'b1;
    end
    if (counted && !changed && quiet_r != COUNT_MAX) begin
      qt_new = quiet_r + 1'b1;
    end
    ovf_new = ovf_r | ~head_item.in_range;
    changed_nxt = changed_r;
    quiet_nxt   = quiet_r;
    ovf_nxt     = ovf_r;
    if (pop) begin
      changed_nxt = head_item.last ? '0 : ch_new;
      quiet_nxt   = head_item.last ? '0 : qt_new;
      ovf_nxt     = head_item.last ? 1'b0 : ovf_new;
    end
  end

  always_comb begin
    red   = '0;
    green = '0;
    blue  = '0;
    if (!head_item.compare_valid) begin
      red = '0;
    end else if (cfg.plain && head_item.masked) begin
      red = '0;
    end else if (cfg.plain) begin
      red   = head_item.luma;
      green = head_item.luma;
      blue  = head_item.luma;
    end else if (head_item.masked) begin
      red = dim;
    end else begin
      red   = dim;
      green = changed ? PIX_MAX : dim;
      blue  = dim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r   <= '0;
      quiet_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      changed_r <= changed_nxt;
      quiet_r   <= quiet_nxt;
      ovf_r     <= ovf_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      red_r     <= red;
      green_r   <= green;
      blue_r    <= blue;
      cmp_r     <= head_item.compare_valid;
      last_r    <= head_item.last;
      ch_out_r  <= (head_item.last && head_item.compare_valid) ? ch_new : '0;
      qt_out_r  <= (head_item.last && head_item.compare_valid) ? qt_new : '0;
      motion_r  <= head_item.last & head_item.compare_valid & (ch_new >= cfg.threshold);
      ovf_out_r <= head_item.last & ovf_new;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, qt_out_r, ch_out_r, blue_r, green_r, red_r};
  assign out_tuser  = {ovf_out_r, motion_r, cmp_r};
  assign out_tlast  = last_r;

endmodule

// ===== design/frame_difference_motion_detector.sv =====
// Frame difference motion detector top level: configuration registers and
// the front, queue and back parts. Depends on fdmd_pkg and the submodules.
//
// The block takes one pixel per clock while in_tready is high and out_tready does not
// stall it, and gives one result item per pixel, with no gaps between frames.
// A result passes the registered read of the 64K x 8 frame store, the queue
// and the output register after its pixel is accepted. The frame store has one port
// that is read and rewritten at the same address in the accept cycle, which sets the
// one-pixel-per-clock figure. The store needs no clearing after reset; the first frame
// after reset or after a restart only fills it. Counts, the motion event and the overflow
// flag appear on the result item of the last pixel of a frame.
module frame_difference_motion_detector import fdmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // luma
  input  logic [1:0]        in_tuser,    // masked, restart_reference
  input  logic              in_tlast,    // last_pixel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,   // red, green, blue, changed_count, quiet_count
  output logic [2:0]        out_tuser,   // compare_valid, motion_event, frame_overflow
  output logic              out_tlast,   // frame_end
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  fdmd_cfg_t         cfg_r;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  logic              push, pop, head_valid;
  fdmd_item_t        push_item, head_item;
  logic [QCNT_W-1:0] q_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.squelch   <= SQUELCH_RST;
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.plain     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SQUELCH:   cfg_r.squelch   <= cfg_pwdata[LUMA_W-1:0];
        REG_THRESHOLD: cfg_r.threshold <= cfg_pwdata[CNT_W-1:0];
        REG_PLAIN:     cfg_r.plain     <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SQUELCH:   cfg_prdata = CFG_DW'(cfg_r.squelch);
      REG_THRESHOLD: cfg_prdata = CFG_DW'(cfg_r.threshold);
      REG_PLAIN:     cfg_prdata = CFG_DW'(cfg_r.plain);
      default:       cfg_prdata = '0;
    endcase
  end

  fdmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  fdmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  fdmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/tb_frame_difference_motion_detector.sv =====
`timescale 1ns / 1ps
// Self-checking bench for frame_difference_motion_detector: short directed frames, a frame
// that fills 200 store entries and a frame with each luma MSB flipped compared against it,
// then random frames under several register settings. Depends only on fdmd_pkg and the RTL.
module tb_frame_difference_motion_detector;
  import fdmd_pkg::*;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          compare_valid;
    bit          frame_end;
    int unsigned changed_count;
    int unsigned quiet_count;
    bit          motion_event;
    bit          frame_overflow;
  } overlay_result_t;

  typedef enum int {LUMA_RANDOM, LUMA_NEAR, LUMA_FLIP} luma_pattern_t;

  class frame_diff_scoreboard;
    bit [LUMA_W-1:0] frame_store [MAX_PIXELS];
    bit              have_ref;
    int unsigned     pos;
    int unsigned     changed_n;
    int unsigned     quiet_n;
    bit              overflow_seen;
    bit [LUMA_W-1:0] squelch = SQUELCH_RST;
    bit [CNT_W-1:0]  threshold = THRESHOLD_RST;
    bit              plain;
    overlay_result_t pending_overlays[$];
    int              errors;

    function void note_pixel(bit [7:0] luma, bit masked, bit last, bit restart);
      overlay_result_t r;
      bit [7:0] old_luma;
      bit [7:0] diff;
      bit [7:0] dim;
      bit valid;
      bit in_range;
      bit changed;
      if (pos == 0 && restart) have_ref = 1'b0;
      valid = have_ref;
      in_range = pos < MAX_PIXELS;
      if (in_range) begin
        old_luma = frame_store[pos];
        frame_store[pos] = luma;
        pos++;
      end else begin
        old_luma = luma;
        overflow_seen = 1'b1;
      end
      diff = (old_luma > luma) ? old_luma - luma : luma - old_luma;
      changed = diff > squelch;
      dim = luma >> DIM_SHIFT;
      if (valid && in_range && !masked) begin
        if (changed && changed_n < COUNT_MAX) changed_n++;
        if (!changed && quiet_n < COUNT_MAX) quiet_n++;
      end
      r = '{default: 0};
      if (valid && !masked) begin
        if (plain) begin
          r.red = luma;
          r.green = luma;
          r.blue = luma;
        end else begin
          r.red = dim;
          r.green = changed ? PIX_MAX : dim;
          r.blue = dim;
        end
      end else if (valid && !plain) begin
        r.red = dim;
      end
      r.compare_valid = valid;
      r.frame_end = last;
      if (last) begin
        if (valid) begin
          r.changed_count = changed_n;
          r.quiet_count = quiet_n;
          r.motion_event = changed_n >= threshold;
        end
        r.frame_overflow = overflow_seen;
        have_ref = 1'b1;
        pos = 0;
        changed_n = 0;
        quiet_n = 0;
        overflow_seen = 1'b0;
      end
      pending_overlays.insert(pending_overlays.size(), r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_overlay(logic [63:0] tdata, logic [2:0] tuser, logic tlast);
      overlay_result_t want;
      if (pending_overlays.size() == 0) begin
        $error("result item with no pixel pending");
        errors++;
        return;
      end
      want = pending_overlays.pop_front();
      check_field("overlay_red", 32'(want.red), 32'(tdata[7:0]));
      check_field("overlay_green", 32'(want.green), 32'(tdata[15:8]));
      check_field("overlay_blue", 32'(want.blue), 32'(tdata[23:16]));
      check_field("changed_count", want.changed_count, 32'(tdata[40:24]));
      check_field("quiet_count", want.quiet_count, 32'(tdata[57:41]));
      check_field("compare_valid", 32'(want.compare_valid), 32'(tuser[0]));
      check_field("motion_event", 32'(want.motion_event), 32'(tuser[1]));
      check_field("frame_overflow", 32'(want.frame_overflow), 32'(tuser[2]));
      check_field("frame_end", 32'(want.frame_end), 32'(tlast));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;    // luma
  logic [1:0]        in_tuser;    // masked, restart_reference
  logic              in_tlast;    // last_pixel
  logic              out_tvalid;
  logic              out_tready;
  logic [63:0]       out_tdata;   // red, green, blue, changed_count, quiet_count
  logic [2:0]        out_tuser;   // compare_valid, motion_event, frame_overflow
  logic              out_tlast;   // frame_end
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  frame_diff_scoreboard sb;
  bit                   no_gaps;
  int                   phase_no;

  frame_difference_motion_detector DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_pixel(input bit [7:0] luma, input bit masked, input bit last,
                            input bit restart);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= luma;
    in_tuser <= {restart, masked};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(luma, masked, last, restart);
  endtask

  task automatic send_frame(input int unsigned len, input bit restart,
                            input luma_pattern_t pattern, input int mask_odds);
    bit [7:0] ref_px;
    bit [7:0] luma;
    bit       masked;
    bit       rs;
    int       off;
    int       sq;
    for (int unsigned i = 0; i < len; i++) begin
      ref_px = (i < MAX_PIXELS) ? sb.frame_store[i] : 8'd0;
      sq = sb.squelch;
      case (pattern)
        LUMA_FLIP: luma = ref_px ^ 8'h80;
        LUMA_NEAR: begin
          off = ($urandom_range(0, 3) == 0) ? sq + int'($urandom_range(0, 1))
                                            : int'($urandom_range(0, 2 * sq + 4)) - (sq + 2);
          if ($urandom_range(0, 1) == 1) off = -off;
          off += ref_px;
          luma = (off < 0) ? 8'd0 : (off > 255) ? 8'd255 : 8'(off);
        end
        default: luma = 8'($urandom);
      endcase
      masked = mask_odds > 0 && $urandom_range(1, mask_odds) == 1;
      rs = (i == 0) ? restart : ($urandom_range(0, 15) == 0);
      send_pixel(luma, masked, i == len - 1, rs);
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'({index, 2'b00});
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (index)
      REG_SQUELCH: sb.squelch = value[LUMA_W-1:0];
      REG_THRESHOLD: sb.threshold = value[CNT_W-1:0];
      REG_PLAIN: sb.plain = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input bit [7:0] sq, input bit [16:0] thr, input bit pl);
    write_reg(REG_SQUELCH, CFG_DW'(sq));
    write_reg(REG_THRESHOLD, CFG_DW'(thr));
    write_reg(REG_PLAIN, CFG_DW'(pl));
  endtask

  task automatic drain_overlays();
    in_tvalid <= 1'b0;
    while (sb.pending_overlays.size() != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    bit held;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (phase_no == 3 && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_overlay(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned max_len;
    bit [7:0]    sq;
    bit [16:0]   thr;
    bit          pl;
    sb = new();
    no_gaps = 1'b0;
    phase_no = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    in_tlast <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first frame only fills the store; the second one is compared against it.
    send_pixel(8'd0, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd255, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd128, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd1, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b0, 1'b0);
    send_pixel(8'd0, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd178, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd52, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b0, 1'b1);
    send_pixel(8'd3, 1'b1, 1'b1, 1'b0);
    send_pixel(8'd200, 1'b0, 1'b1, 1'b0);
    send_pixel(8'd77, 1'b0, 1'b1, 1'b1);
    drain_overlays();
    apply_settings(SQUELCH_RST, 17'd0, 1'b1);
    send_pixel(8'd0, 1'b1, 1'b0, 1'b0);
    send_pixel(8'd255, 1'b0, 1'b1, 1'b0);
    drain_overlays();

    // A frame that fills every position later frames use, then one where every pixel
    // changes, so the count lands exactly on the threshold.
    no_gaps = 1'b1;
    apply_settings(8'd0, 17'd200, 1'b0);
    send_frame(200, 1'b1, LUMA_RANDOM, 4);
    send_frame(200, 1'b0, LUMA_FLIP, 0);
    drain_overlays();

    for (int ph = 1; ph <= 8; ph++) begin
      phase_no = ph;
      no_gaps = (ph % 3 == 2);
      case (ph)
        1: begin sq = 8'd50; thr = 17'd8; pl = 1'b0; end
        2: begin sq = 8'd0; thr = 17'd0; pl = 1'b0; end
        3: begin sq = 8'($urandom); thr = 17'($urandom_range(0, 30)); pl = 1'b0; end
        4: begin sq = 8'd255; thr = 17'd1; pl = 1'b1; end
        5: begin sq = 8'($urandom); thr = 17'h10000; pl = 1'b0; end
        6: begin sq = 8'd1; thr = 17'd65535; pl = 1'b1; end
        default: begin
          sq = 8'($urandom);
          thr = 17'($urandom_range(0, 40));
          pl = 1'($urandom);
        end
      endcase
      apply_settings(sq, thr, pl);
      sent = 0;
      while (sent < 150) begin
        max_len = ($urandom_range(0, 7) == 0) ? 200 : 40;
        len = $urandom_range(1, max_len);
        send_frame(len, $urandom_range(0, 9) == 0,
                   ($urandom_range(0, 4) == 0) ? LUMA_RANDOM : LUMA_NEAR, 4);
        sent += len;
      end
      drain_overlays();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== frame_difference_motion_detector.f =====
+incdir+design
design/fdmd_pkg.sv
design/fdmd_front.sv
design/fdmd_queue.sv
design/fdmd_back.sv
design/frame_difference_motion_detector.sv
bench/tb_frame_difference_motion_detector.sv
